[design/sng_pkg.sv]
// sng_pkg: shared widths, register codes, channel config struct and the
// attenuation-to-level table of the square and noise sound generator.
// No dependencies; used by every module of the block.
`default_nettype none

package sng_pkg;

   // channel counts and field widths
   localparam int NUM_CH    = 4;
   localparam int TONE_CH   = 3;
   localparam int CH_W      = 2;
   localparam int REG_W     = 3;
   localparam int BYTE_W    = 8;
   localparam int ATT_W     = 4;
   localparam int DIV_W     = 10;
   localparam int DIV_SHIFT = 10;
   localparam int PHASE_W   = 21;
   localparam int STEP_W    = 16;
   localparam int SEED_W    = 16;
   localparam int LEVEL_W   = 13;
   localparam int SAMPLE_W  = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // request opcodes
   localparam logic OP_PORT_WRITE  = 1'b0;
   localparam logic OP_SAMPLE_TICK = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_SEED    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POWER_ON_SEED = 2'd2;

   // reset values
   localparam logic [STEP_W-1:0] PHASE_STEP_RESET = 16'd5195;
   localparam logic [SEED_W-1:0] NOISE_SEED_RESET = 16'h8000;
   localparam logic [SEED_W-1:0] POWER_ON_SEED    = 16'h8000;
   localparam logic [ATT_W-1:0]  ATT_SILENT       = 4'hF;

   // noise control register and its rate codes
   localparam logic [REG_W-1:0] NOISE_CTRL_REG   = 3'd6;
   localparam logic [1:0]       NOISE_RATE_16    = 2'd0;
   localparam logic [1:0]       NOISE_RATE_32    = 2'd1;
   localparam logic [1:0]       NOISE_RATE_64    = 2'd2;
   localparam logic [DIV_W-1:0] NOISE_DIV_16     = 10'h010;
   localparam logic [DIV_W-1:0] NOISE_DIV_32     = 10'h020;
   localparam logic [DIV_W-1:0] NOISE_DIV_64     = 10'h040;
   localparam logic [SEED_W-1:0] WHITE_TAPS      = 16'h0009;

   typedef logic [ATT_W-1:0] att_type;
   typedef logic [DIV_W-1:0] div_type;

   // channel settings handed from the port register file to the voices
   typedef struct packed {
      att_type [NUM_CH-1:0] attenuation;
      div_type [NUM_CH-1:0] divider;
      logic                 white_mode;
      logic                 noise_reload;
   } sng_voice_cfg_type;

   // attenuation code to output magnitude (five times the base volume steps)
   function automatic logic [LEVEL_W-1:0] level_of(input att_type att);
      logic [LEVEL_W-1:0] lvl;
      case (att)
         4'd0, 4'd1, 4'd2: lvl = 13'd4460;
         4'd3:  lvl = 13'd3800;
         4'd4:  lvl = 13'd3115;
         4'd5:  lvl = 13'd2485;
         4'd6:  lvl = 13'd2020;
         4'd7:  lvl = 13'd1615;
         4'd8:  lvl = 13'd1285;
         4'd9:  lvl = 13'd990;
         4'd10: lvl = 13'd795;
         4'd11: lvl = 13'd615;
         4'd12: lvl = 13'd480;
         4'd13: lvl = 13'd375;
         4'd14: lvl = 13'd300;
         default: lvl = 13'd0;
      endcase
      return lvl;
   endfunction

endpackage

`default_nettype wire

[design/square_noise_sound_generator.sv]
// Square and noise sound generator: three square tones plus one noise
// channel, mixed into one signed 16-bit sample per tick request.
//
// Request channel (req_): req_opcode 0 writes req_data_byte to the sound
// port (latch byte with bit 7 set, data byte otherwise) and returns nothing;
// req_opcode 1 is a sample tick and returns one rsp_sample.
// A request is held in the input register and a tick's sample is then
// registered into the result register that drives rsp_valid and rsp_sample.
// Throughput is one request per clock while req_stall is low; the limit is
// the single result register, so req_stall rises only while a tick waits
// in the input register behind a stalled, full result register.
// Configuration (csr_): index 0 phase step, 1 noise seed (loaded on each
// noise control write), 2 power-on seed (the reset seed is fixed at 0x8000,
// so writes there have no effect). csr_ready is always high; write only
// while idle.
// Reset (synchronous): all channels silent, levels high, noise register at
// the power-on seed, phase counters and dividers cleared, CSRs to defaults.
// With rsp_stall high the held sample stays on rsp_sample.
`default_nettype none

module square_noise_sound_generator (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_opcode,
   input  wire logic [sng_pkg::BYTE_W-1:0]       req_data_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic signed [sng_pkg::SAMPLE_W-1:0]   rsp_sample,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [sng_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [sng_pkg::CSR_DATA_W-1:0]   csr_data
);

   logic [sng_pkg::STEP_W-1:0]          phase_step_ff, phase_step_in;
   logic [sng_pkg::SEED_W-1:0]          noise_seed_ff, noise_seed_in;
   logic                                in_valid_ff, in_valid_in;
   logic                                in_opcode_ff;
   logic [sng_pkg::BYTE_W-1:0]          in_byte_ff;
   logic                                out_valid_ff, out_valid_in;
   logic signed [sng_pkg::SAMPLE_W-1:0] out_sample_ff;
   logic                                req_accept;
   logic                                out_free;
   logic                                port_we;
   logic                                tick_en;
   logic                                advance;
   logic signed [sng_pkg::SAMPLE_W-1:0] sample_next;
   sng_pkg::sng_voice_cfg_type          voice_cfg;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      phase_step_in = phase_step_ff;
      noise_seed_in = noise_seed_ff;
      if (csr_valid) begin
         unique case (csr_index)
            sng_pkg::CSR_PHASE_STEP:    phase_step_in = csr_data;
            sng_pkg::CSR_NOISE_SEED:    noise_seed_in = csr_data;
            sng_pkg::CSR_POWER_ON_SEED: noise_seed_in = noise_seed_ff;
            default:                    phase_step_in = phase_step_ff;
         endcase
      end
   end

   // input register and execute control
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign port_we    = in_valid_ff && (in_opcode_ff == sng_pkg::OP_PORT_WRITE);
   assign tick_en    = in_valid_ff && (in_opcode_ff == sng_pkg::OP_SAMPLE_TICK) && out_free;
   assign advance    = !in_valid_ff || port_we || tick_en;
   assign req_stall  = !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) begin
         in_valid_in = req_valid;
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (tick_en) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= sng_pkg::PHASE_STEP_RESET;
         noise_seed_ff <= sng_pkg::NOISE_SEED_RESET;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         phase_step_ff <= phase_step_in;
         noise_seed_ff <= noise_seed_in;
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_opcode_ff <= req_opcode;
         in_byte_ff   <= req_data_byte;
      end
      if (tick_en) begin
         out_sample_ff <= sample_next;
      end
   end

   // port register file
   sng_port_regs u_port_regs (
      .clock     (clock),
      .reset     (reset),
      .write_en  (port_we),
      .data_byte (in_byte_ff),
      .voice_cfg (voice_cfg)
   );

   // tone and noise voices with mixer
   sng_voices u_voices (
      .clock       (clock),
      .reset       (reset),
      .tick_en     (tick_en),
      .phase_step  (phase_step_ff),
      .noise_seed  (noise_seed_ff),
      .voice_cfg   (voice_cfg),
      .sample_next (sample_next)
   );

   assign rsp_valid  = out_valid_ff;
   assign rsp_sample = out_sample_ff;

`ifndef SYNTHESIS
   // back-pressure only comes from a tick blocked by the result register
   a_stall_only_tick: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && in_opcode_ff == sng_pkg::OP_SAMPLE_TICK
                     && out_valid_ff && rsp_stall))
      else $error("request stalled without a blocked tick");

   // an executed tick always shows up as a result
   a_tick_gives_result: assert property (@(posedge clock) disable iff (reset)
      tick_en |=> (rsp_valid && rsp_sample == $past(sample_next)))
      else $error("tick did not produce its sample");

   // a port write never creates a result
   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (port_we && !rsp_stall) |=> !rsp_valid)
      else $error("port write produced a result");

   // mixed sample stays within the level table's range
   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample >= -16'sd13380 && rsp_sample <= 16'sd17840))
      else $error("sample out of range");
`endif

endmodule

`default_nettype wire

[design/sng_phase_acc.sv]
// sng_phase_acc: one channel's phase accumulator; advances by the phase
// step on each tick and flags a wrap on reaching divider times 1024. Uses sng_pkg.
`default_nettype none

module sng_phase_acc (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic [sng_pkg::STEP_W-1:0]    phase_step,
   input  wire sng_pkg::div_type              divider,
   output logic                               wrap
);

   logic [sng_pkg::PHASE_W-1:0] phase_ff;
   logic [sng_pkg::PHASE_W-1:0] phase_in;
   logic [sng_pkg::PHASE_W-1:0] half;
   logic [sng_pkg::PHASE_W-1:0] start;
   logic [sng_pkg::PHASE_W:0]   sum;

   // clamp a stale count, add the step, fold back once on wrap
   always_comb begin
      half  = sng_pkg::PHASE_W'({divider, {sng_pkg::DIV_SHIFT{1'b0}}});
      start = (phase_ff >= half) ? '0 : phase_ff;
      sum   = {1'b0, start} + (sng_pkg::PHASE_W + 1)'(phase_step);
      wrap  = advance && (sum >= {1'b0, half});
      if (!advance) begin
         phase_in = phase_ff;
      end else if (wrap) begin
         phase_in = sng_pkg::PHASE_W'(sum - {1'b0, half});
      end else begin
         phase_in = sng_pkg::PHASE_W'(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

`default_nettype wire

[design/sng_port_regs.sv]
// sng_port_regs: sound port register file; decodes latch and data bytes
// into attenuations, dividers and noise control. Uses sng_pkg.
`default_nettype none

module sng_port_regs (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        write_en,
   input  wire logic [sng_pkg::BYTE_W-1:0]  data_byte,
   output sng_pkg::sng_voice_cfg_type       voice_cfg
);

   logic [sng_pkg::REG_W-1:0]                latched_ff, latched_in;
   sng_pkg::att_type [sng_pkg::NUM_CH-1:0]   att_ff, att_in;
   sng_pkg::div_type [sng_pkg::NUM_CH-1:0]   div_ff, div_in;
   logic                                     follow_ff, follow_in;
   logic                                     white_ff, white_in;
   logic                                     reload;
   logic [sng_pkg::CH_W-1:0]                 ch;
   logic                                     is_att;

   // byte decode and register update
   always_comb begin
      latched_in = latched_ff;
      att_in     = att_ff;
      div_in     = div_ff;
      follow_in  = follow_ff;
      white_in   = white_ff;
      reload     = 1'b0;
      ch         = latched_ff[sng_pkg::REG_W-1:1];
      is_att     = latched_ff[0];
      if (write_en) begin
         if (data_byte[7]) begin
            latched_in = data_byte[6:4];
         end
         ch     = latched_in[sng_pkg::REG_W-1:1];
         is_att = latched_in[0];
         for (int i = 0; i < sng_pkg::NUM_CH; i++) begin
            if (ch == sng_pkg::CH_W'(i)) begin
               if (is_att) begin
                  att_in[i] = data_byte[3:0];
               end else if (data_byte[7]) begin
                  div_in[i] = {div_ff[i][sng_pkg::DIV_W-1:4], data_byte[3:0]};
               end else if (i != sng_pkg::NUM_CH - 1) begin
                  div_in[i] = {data_byte[5:0], div_ff[i][3:0]};
               end
            end
         end
         // in follow mode, noise follows tone 2 whenever tone 2's divider is written
         if (follow_ff && !is_att && ch == sng_pkg::CH_W'(2)) begin
            div_in[3] = div_in[2];
         end
         // noise control: reseed, pick rate, pick feedback
         if (latched_in == sng_pkg::NOISE_CTRL_REG) begin
            reload = 1'b1;
            case (data_byte[1:0])
               sng_pkg::NOISE_RATE_16: begin
                  div_in[3] = sng_pkg::NOISE_DIV_16;
                  follow_in = 1'b0;
               end
               sng_pkg::NOISE_RATE_32: begin
                  div_in[3] = sng_pkg::NOISE_DIV_32;
                  follow_in = 1'b0;
               end
               sng_pkg::NOISE_RATE_64: begin
                  div_in[3] = sng_pkg::NOISE_DIV_64;
                  follow_in = 1'b0;
               end
               default: begin
                  div_in[3] = div_in[2];
                  follow_in = 1'b1;
               end
            endcase
            white_in = data_byte[2];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latched_ff <= '0;
         follow_ff  <= 1'b0;
         white_ff   <= 1'b1;
         for (int i = 0; i < sng_pkg::NUM_CH; i++) begin
            att_ff[i] <= sng_pkg::ATT_SILENT;
            div_ff[i] <= '0;
         end
      end else begin
         latched_ff <= latched_in;
         follow_ff  <= follow_in;
         white_ff   <= white_in;
         att_ff     <= att_in;
         div_ff     <= div_in;
      end
   end

   // settings for the voices; the reseed pulse lands on the write edge
   assign voice_cfg.attenuation  = att_ff;
   assign voice_cfg.divider      = div_ff;
   assign voice_cfg.white_mode   = white_ff;
   assign voice_cfg.noise_reload = reload;

endmodule

`default_nettype wire

[design/sng_voices.sv]
// sng_voices: four phase accumulators, tone levels, noise shift register
// and the output mixer. Uses sng_pkg and sng_phase_acc.
`default_nettype none

module sng_voices (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          tick_en,
   input  wire logic [sng_pkg::STEP_W-1:0]    phase_step,
   input  wire logic [sng_pkg::SEED_W-1:0]    noise_seed,
   input  wire sng_pkg::sng_voice_cfg_type    voice_cfg,
   output logic signed [sng_pkg::SAMPLE_W-1:0] sample_next
);

   logic [sng_pkg::NUM_CH-1:0] wrap;
   logic [sng_pkg::NUM_CH-1:0] level_ff, level_in;
   logic [sng_pkg::SEED_W-1:0] noise_ff, noise_in;
   logic                       feedback;
   logic signed [sng_pkg::SAMPLE_W-1:0] mag;

   // one accumulator per channel
   for (genvar g = 0; g < sng_pkg::NUM_CH; g++) begin : g_acc
      sng_phase_acc u_acc (
         .clock      (clock),
         .reset      (reset),
         .advance    (tick_en),
         .phase_step (phase_step),
         .divider    (voice_cfg.divider[g]),
         .wrap       (wrap[g])
      );
   end

   // level toggles and noise shift
   always_comb begin
      level_in = level_ff;
      noise_in = noise_ff;
      feedback = voice_cfg.white_mode ? ^(noise_ff & sng_pkg::WHITE_TAPS) : noise_ff[0];
      if (voice_cfg.noise_reload) begin
         noise_in = noise_seed;
      end else if (tick_en) begin
         for (int i = 0; i < sng_pkg::TONE_CH; i++) begin
            if (voice_cfg.divider[i] <= sng_pkg::DIV_W'(1)) begin
               level_in[i] = 1'b1;
            end else begin
               level_in[i] = level_ff[i] ^ wrap[i];
            end
         end
         if (wrap[3]) begin
            noise_in    = {feedback, noise_ff[sng_pkg::SEED_W-1:1]};
            level_in[3] = noise_in[0];
         end
      end
   end

   // mixer: bipolar tones, unipolar noise
   always_comb begin
      sample_next = '0;
      mag         = '0;
      for (int i = 0; i < sng_pkg::TONE_CH; i++) begin
         mag = sng_pkg::SAMPLE_W'(sng_pkg::level_of(voice_cfg.attenuation[i]));
         sample_next = level_in[i] ? sample_next + mag : sample_next - mag;
      end
      mag = sng_pkg::SAMPLE_W'(sng_pkg::level_of(voice_cfg.attenuation[3]));
      if (level_in[3]) begin
         sample_next = sample_next + mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '1;
         noise_ff <= sng_pkg::POWER_ON_SEED;
      end else begin
         level_ff <= level_in;
         noise_ff <= noise_in;
      end
   end

endmodule

`default_nettype wire
